// ----- rtl/lfv_pkg.sv -----
package lfv_pkg;

   // saturation width of position and velocity results
   localparam int VALUE_WIDTH = 32;

   localparam int DATA_W  = 32;
   localparam int DT_W    = 24;
   localparam int DTSUM_W = DT_W + 1;
   localparam int IM_W    = 31;
   localparam int SIZE_W  = 31;
   localparam int NUM_AXES = 3;
   localparam int CSR_IDX_W = 8;

   // register stages from request to result
   localparam int PIPE_DEPTH = 10;

   // width of the pre-saturation velocity and position values
   localparam int SAT_W = 48;

   localparam logic signed [SAT_W-1:0] SAT_HI =
      SAT_W'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
   localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DT_PREV    = 8'd0,
      REG_DT_NEXT    = 8'd1,
      REG_BOX_LOW_X  = 8'd2,
      REG_BOX_LOW_Y  = 8'd3,
      REG_BOX_LOW_Z  = 8'd4,
      REG_BOX_SIZE_X = 8'd5,
      REG_BOX_SIZE_Y = 8'd6,
      REG_BOX_SIZE_Z = 8'd7
   } csr_index_type;

   typedef struct packed {
      logic [DT_W-1:0]                     dt_next;
      logic [DTSUM_W-1:0]                  dt_sum;
      logic [NUM_AXES-1:0][DATA_W-1:0]     box_low;
      logic [NUM_AXES-1:0][SIZE_W-1:0]     box_size;
   } cfg_type;

   function automatic logic signed [DATA_W-1:0] sat_value(input logic signed [SAT_W-1:0] x);
      logic signed [SAT_W-1:0] y;
      if (x > SAT_HI) begin
         y = SAT_HI;
      end else if (x < SAT_LO) begin
         y = SAT_LO;
      end else begin
         y = x;
      end
      return DATA_W'(y);
   endfunction

endpackage

// ----- rtl/lfv_csr.sv -----
module lfv_csr import lfv_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [CSR_IDX_W-1:0]  wr_index,
   input  logic [DATA_W-1:0]     wr_data,
   output cfg_type               cfg
);

   logic [DT_W-1:0]                 dt_prev_ff, dt_prev_in;
   logic [DT_W-1:0]                 dt_next_ff, dt_next_in;
   logic [DTSUM_W-1:0]              dt_sum_ff;
   logic [NUM_AXES-1:0][DATA_W-1:0] box_low_ff, box_low_in;
   logic [NUM_AXES-1:0][SIZE_W-1:0] box_size_ff, box_size_in;

   always_comb begin
      dt_prev_in  = dt_prev_ff;
      dt_next_in  = dt_next_ff;
      box_low_in  = box_low_ff;
      box_size_in = box_size_ff;
      if (wr_en) begin
         case (wr_index)
            REG_DT_PREV:    dt_prev_in     = wr_data[DT_W-1:0];
            REG_DT_NEXT:    dt_next_in     = wr_data[DT_W-1:0];
            REG_BOX_LOW_X:  box_low_in[0]  = wr_data;
            REG_BOX_LOW_Y:  box_low_in[1]  = wr_data;
            REG_BOX_LOW_Z:  box_low_in[2]  = wr_data;
            REG_BOX_SIZE_X: box_size_in[0] = wr_data[SIZE_W-1:0];
            REG_BOX_SIZE_Y: box_size_in[1] = wr_data[SIZE_W-1:0];
            REG_BOX_SIZE_Z: box_size_in[2] = wr_data[SIZE_W-1:0];
            default: begin
               // unknown index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_prev_ff  <= '0;
         dt_next_ff  <= '0;
         dt_sum_ff   <= '0;
         box_low_ff  <= '0;
         box_size_ff <= '0;
      end else begin
         dt_prev_ff  <= dt_prev_in;
         dt_next_ff  <= dt_next_in;
         // sum of steps read as q0.25 gives the factor one half
         dt_sum_ff   <= DTSUM_W'(dt_prev_ff) + DTSUM_W'(dt_next_ff);
         box_low_ff  <= box_low_in;
         box_size_ff <= box_size_in;
      end
   end

   assign cfg.dt_next  = dt_next_ff;
   assign cfg.dt_sum   = dt_sum_ff;
   assign cfg.box_low  = box_low_ff;
   assign cfg.box_size = box_size_ff;

endmodule

// ----- rtl/lfv_axis.sv -----
module lfv_axis import lfv_pkg::*; (
   input  logic                      clock,
   input  logic signed [DATA_W-1:0]  pos,
   input  logic signed [DATA_W-1:0]  vel,
   input  logic signed [DATA_W-1:0]  force_in,
   input  logic [IM_W-1:0]           inv_mass,
   input  logic signed [DATA_W-1:0]  box_low,
   input  logic [SIZE_W-1:0]         box_size,
   input  logic [DT_W-1:0]           dt_next,
   input  logic [DTSUM_W-1:0]        dt_sum,
   output logic signed [DATA_W-1:0]  new_pos,
   output logic signed [DATA_W-1:0]  new_vel
);

   localparam int M_W   = 62;
   localparam int LO_W  = 32 + DTSUM_W;
   localparam int HI_W  = (M_W - 32) + DTSUM_W;
   localparam int ACC_W = 88;
   localparam int G_W   = 46;
   localparam int PR_W  = DATA_W + DT_W;
   localparam int ST_W  = 33;
   localparam int NP_W  = 36;

   // carried through the pipe for the velocity and position adds and the fixed-atom bypass
   logic signed [8:0][DATA_W-1:0] p_ff, p_in;
   logic signed [8:0][DATA_W-1:0] v_ff, v_in;
   logic [8:0]                    fix_ff, fix_in;
   logic [3:0]                    fneg_ff, fneg_in;
   logic [2:0]                    vneg_ff, vneg_in;

   logic [DATA_W-1:0]       fm1_ff, fm1_in;
   logic [IM_W-1:0]         im1_ff;
   logic [M_W-1:0]          m2_ff, m2_in;
   logic [2*DATA_W-2:0]     mprod;
   logic [LO_W-1:0]         lo3_ff, lo3_in;
   logic [HI_W-1:0]         hi3_ff, hi3_in;
   logic [ACC_W-1:0]        acc;
   logic [G_W-1:0]          q4_ff, q4_in;
   logic signed [SAT_W-1:0] nvw;
   logic signed [DATA_W-1:0] nv5_ff, nv5_in;
   logic [DATA_W-1:0]       vm6_ff, vm6_in;
   logic [PR_W-1:0]         pr7_ff, pr7_in;
   logic [PR_W:0]           rnd;
   logic [ST_W-1:0]         q8_ff, q8_in;
   logic signed [NP_W-1:0]  np9_ff, np9_in;
   logic signed [NP_W-1:0]  hb9_ff, hb9_in;
   logic signed [DATA_W-1:0] nv_ff [6:9];
   logic signed [NP_W-1:0]  low36, size36, wrapped;
   logic signed [DATA_W-1:0] pos_out_ff, pos_out_in;
   logic signed [DATA_W-1:0] vel_out_ff, vel_out_in;

   always_comb begin
      // side band shift
      p_in[0]    = pos;
      v_in[0]    = vel;
      fix_in[0]  = (inv_mass == '0);
      fneg_in[0] = force_in[DATA_W-1];
      for (int i = 1; i < 9; i++) begin
         p_in[i]   = p_ff[i-1];
         v_in[i]   = v_ff[i-1];
         fix_in[i] = fix_ff[i-1];
      end
      for (int i = 1; i < 4; i++) begin
         fneg_in[i] = fneg_ff[i-1];
      end

      // stage 1: force magnitude
      fm1_in = force_in[DATA_W-1] ? (~force_in + DATA_W'(1)) : force_in;

      // stage 2: inv_mass * |force|, below 2^62
      mprod = {DATA_W'(0), im1_ff} * {(DATA_W-1)'(0), fm1_ff};
      m2_in = mprod[M_W-1:0];

      // stage 3: split product times step sum
      lo3_in = LO_W'(m2_ff[31:0]) * LO_W'(dt_sum);
      hi3_in = HI_W'(m2_ff[M_W-1:32]) * HI_W'(dt_sum);

      // stage 4: combine, round half away (on magnitude) and drop 41 bits
      acc   = {hi3_ff, 32'd0} + ACC_W'(lo3_ff) + (ACC_W'(1) << 40);
      q4_in = acc[41 +: G_W];

      // stage 5: velocity update with saturation
      nvw    = SAT_W'($signed(v_ff[3])) + (fneg_ff[3] ? -$signed({2'b00, q4_ff})
                                                     :  $signed({2'b00, q4_ff}));
      nv5_in = sat_value(nvw);

      // stage 6: velocity magnitude
      vneg_in[0] = nv5_ff[DATA_W-1];
      vneg_in[1] = vneg_ff[0];
      vneg_in[2] = vneg_ff[1];
      vm6_in = nv5_ff[DATA_W-1] ? (~nv5_ff + DATA_W'(1)) : nv5_ff;

      // stage 7: |v| * dt_next
      pr7_in = PR_W'(vm6_ff) * PR_W'(dt_next);

      // stage 8: round to q16.16
      rnd   = {1'b0, pr7_ff} + ((PR_W+1)'(1) << 23);
      q8_in = rnd[24 +: ST_W];

      // stage 9: position advance and upper bound
      low36  = NP_W'(box_low);
      size36 = $signed({5'b00000, box_size});
      np9_in = NP_W'($signed(p_ff[7])) + (vneg_ff[2] ? -$signed({3'b000, q8_ff})
                                                      :  $signed({3'b000, q8_ff}));
      hb9_in = low36 + size36;

      // stage 10: single wrap, saturate, fixed-atom bypass
      if (np9_ff < low36) begin
         wrapped = np9_ff + size36;
      end else if (np9_ff > hb9_ff) begin
         wrapped = np9_ff - size36;
      end else begin
         wrapped = np9_ff;
      end
      if (fix_ff[8]) begin
         pos_out_in = p_ff[8];
         vel_out_in = v_ff[8];
      end else begin
         pos_out_in = sat_value(SAT_W'(wrapped));
         vel_out_in = nv_ff[9];
      end
   end

   always_ff @(posedge clock) begin
      p_ff       <= p_in;
      v_ff       <= v_in;
      fix_ff     <= fix_in;
      fneg_ff    <= fneg_in;
      vneg_ff    <= vneg_in;
      fm1_ff     <= fm1_in;
      im1_ff     <= inv_mass;
      m2_ff      <= m2_in;
      lo3_ff     <= lo3_in;
      hi3_ff     <= hi3_in;
      q4_ff      <= q4_in;
      nv5_ff     <= nv5_in;
      nv_ff[6]   <= nv5_ff;
      nv_ff[7]   <= nv_ff[6];
      nv_ff[8]   <= nv_ff[7];
      nv_ff[9]   <= nv_ff[8];
      vm6_ff     <= vm6_in;
      pr7_ff     <= pr7_in;
      q8_ff      <= q8_in;
      np9_ff     <= np9_in;
      hb9_ff     <= hb9_in;
      pos_out_ff <= pos_out_in;
      vel_out_ff <= vel_out_in;
   end

   assign new_pos = pos_out_ff;
   assign new_vel = vel_out_ff;

endmodule

// ----- rtl/leapfrog_verlet_pbc_step.sv -----
// leapfrog integrator step for one atom per request, with a periodic box
//
// request channel: drive the atom's position, velocity, force and inverse
// mass on the req_ ports and raise start; the request is taken at any rising
// edge where start is high and busy is low. busy stays low, so one request
// can be taken in every cycle.
// result channel: rsp_valid is high for exactly one cycle while the new
// position and velocity sit on the rsp_ ports. the receiver cannot hold
// results off, and the pipe never stalls.
// pipeline: ten register stages; the result comes from the last of them.
// throughput is one atom per cycle, set by the fully pipelined multipliers
// (inv_mass*force, times the step sum in two partial products, then velocity
// times dt_next).
// configuration: registers 0..7 (dt_prev, dt_next, box low x/y/z, box size
// x/y/z) are written through csr_valid/csr_ready, always ready; write them
// only while no request is in flight. an unknown index is ignored.
// reset: synchronous, clears the configuration registers and valid bits to
// zero and drops every request in flight; no result comes out for those.
module leapfrog_verlet_pbc_step import lfv_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     start,
   output logic                     busy,
   input  logic signed [DATA_W-1:0] req_pos_x,
   input  logic signed [DATA_W-1:0] req_pos_y,
   input  logic signed [DATA_W-1:0] req_pos_z,
   input  logic signed [DATA_W-1:0] req_vel_x,
   input  logic signed [DATA_W-1:0] req_vel_y,
   input  logic signed [DATA_W-1:0] req_vel_z,
   input  logic signed [DATA_W-1:0] req_force_x,
   input  logic signed [DATA_W-1:0] req_force_y,
   input  logic signed [DATA_W-1:0] req_force_z,
   input  logic [IM_W-1:0]          req_inv_mass,
   // result channel
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_new_pos_x,
   output logic signed [DATA_W-1:0] rsp_new_pos_y,
   output logic signed [DATA_W-1:0] rsp_new_pos_z,
   output logic signed [DATA_W-1:0] rsp_new_vel_x,
   output logic signed [DATA_W-1:0] rsp_new_vel_y,
   output logic signed [DATA_W-1:0] rsp_new_vel_z,
   // configuration write channel
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_wdata
);

   cfg_type                 cfg;
   logic                    req_take;
   logic [PIPE_DEPTH-1:0]   valid_ff, valid_in;

   // pipe never backs up, so requests and config writes are always taken
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign req_take  = start && !busy;

   lfv_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // one datapath per axis, all sharing the step registers
   lfv_axis u_axis_x (
      .clock    (clock),
      .pos      (req_pos_x),
      .vel      (req_vel_x),
      .force_in (req_force_x),
      .inv_mass (req_inv_mass),
      .box_low  ($signed(cfg.box_low[0])),
      .box_size (cfg.box_size[0]),
      .dt_next  (cfg.dt_next),
      .dt_sum   (cfg.dt_sum),
      .new_pos  (rsp_new_pos_x),
      .new_vel  (rsp_new_vel_x)
   );

   lfv_axis u_axis_y (
      .clock    (clock),
      .pos      (req_pos_y),
      .vel      (req_vel_y),
      .force_in (req_force_y),
      .inv_mass (req_inv_mass),
      .box_low  ($signed(cfg.box_low[1])),
      .box_size (cfg.box_size[1]),
      .dt_next  (cfg.dt_next),
      .dt_sum   (cfg.dt_sum),
      .new_pos  (rsp_new_pos_y),
      .new_vel  (rsp_new_vel_y)
   );

   lfv_axis u_axis_z (
      .clock    (clock),
      .pos      (req_pos_z),
      .vel      (req_vel_z),
      .force_in (req_force_z),
      .inv_mass (req_inv_mass),
      .box_low  ($signed(cfg.box_low[2])),
      .box_size (cfg.box_size[2]),
      .dt_next  (cfg.dt_next),
      .dt_sum   (cfg.dt_sum),
      .new_pos  (rsp_new_pos_z),
      .new_vel  (rsp_new_vel_z)
   );

   // valid bit per stage, moves in step with the datapath registers
   assign valid_in = {valid_ff[PIPE_DEPTH-2:0], req_take};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[PIPE_DEPTH-1];

`ifndef SYNTHESIS
   // every result strobe traces back to a matching taken request
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_take, PIPE_DEPTH))
      else $error("result strobe without a matching request");

   // a fixed atom comes out exactly as it went in
   a_fixed_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_inv_mass == '0, PIPE_DEPTH) |->
         rsp_new_pos_x == $past(req_pos_x, PIPE_DEPTH) &&
         rsp_new_pos_y == $past(req_pos_y, PIPE_DEPTH) &&
         rsp_new_pos_z == $past(req_pos_z, PIPE_DEPTH))
      else $error("fixed atom position changed");

   a_fixed_vel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_inv_mass == '0, PIPE_DEPTH) |->
         rsp_new_vel_x == $past(req_vel_x, PIPE_DEPTH) &&
         rsp_new_vel_y == $past(req_vel_y, PIPE_DEPTH) &&
         rsp_new_vel_z == $past(req_vel_z, PIPE_DEPTH))
      else $error("fixed atom velocity changed");
`endif

endmodule

// ----- verif/tb_leapfrog_verlet_pbc_step.sv -----
`timescale 1ns / 1ps

module tb_leapfrog_verlet_pbc_step;
   import lfv_pkg::*;

   // run limit in cycles, far above the slowest legal run
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PHASES = 8;
   localparam int ATOMS_PER_PHASE = 118;
   localparam int MAX_GAP = 12;

   localparam logic signed [DATA_W-1:0] Q16_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] Q16_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] Q16_ONE = 32'sh0001_0000;
   localparam logic [IM_W-1:0] IM_MAX = '1;
   localparam logic [SIZE_W-1:0] SIZE_MAX = '1;
   localparam logic [DT_W-1:0] DT_MAX = '1;
   localparam logic [DT_W-1:0] DT_HALF = 24'h80_0000;

   // register indexes beyond the defined map
   localparam logic [CSR_IDX_W-1:0] FIRST_UNUSED_INDEX = CSR_IDX_W'(REG_BOX_SIZE_Z + 1);
   localparam logic [CSR_IDX_W-1:0] LAST_INDEX = '1;

   // one atom as it enters the integrator
   typedef struct packed {
      logic [NUM_AXES-1:0][DATA_W-1:0] pos;
      logic [NUM_AXES-1:0][DATA_W-1:0] vel;
      logic [NUM_AXES-1:0][DATA_W-1:0] frc;
      logic [IM_W-1:0]                 inv_mass;
   } atom_type;

   // the advanced position and half-step velocity of one atom
   typedef struct packed {
      logic [NUM_AXES-1:0][DATA_W-1:0] pos;
      logic [NUM_AXES-1:0][DATA_W-1:0] vel;
   } motion_type;

   // time steps and periodic box, as held by the block
   typedef struct packed {
      logic [DT_W-1:0]                 dt_prev;
      logic [DT_W-1:0]                 dt_next;
      logic [NUM_AXES-1:0][DATA_W-1:0] box_low;
      logic [NUM_AXES-1:0][SIZE_W-1:0] box_size;
   } step_cfg_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     start = 1'b0;
   logic                     busy;
   logic signed [DATA_W-1:0] req_pos_x = '0;
   logic signed [DATA_W-1:0] req_pos_y = '0;
   logic signed [DATA_W-1:0] req_pos_z = '0;
   logic signed [DATA_W-1:0] req_vel_x = '0;
   logic signed [DATA_W-1:0] req_vel_y = '0;
   logic signed [DATA_W-1:0] req_vel_z = '0;
   logic signed [DATA_W-1:0] req_force_x = '0;
   logic signed [DATA_W-1:0] req_force_y = '0;
   logic signed [DATA_W-1:0] req_force_z = '0;
   logic [IM_W-1:0]          req_inv_mass = '0;

   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_new_pos_x;
   logic signed [DATA_W-1:0] rsp_new_pos_y;
   logic signed [DATA_W-1:0] rsp_new_pos_z;
   logic signed [DATA_W-1:0] rsp_new_vel_x;
   logic signed [DATA_W-1:0] rsp_new_vel_y;
   logic signed [DATA_W-1:0] rsp_new_vel_z;

   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [DATA_W-1:0]        csr_wdata = '0;

   // predictor's copy of the register file, zero after reset
   step_cfg_type step_cfg = '0;
   // predicted motions, oldest first
   motion_type   pending_motion_q[$];

   int  mismatch_count = 0;
   int  atoms_sent = 0;
   int  motions_checked = 0;
   int  reg_writes = 0;
   int  cycle_count = 0;
   // when set, the sender never pauses
   bit  no_idle = 1'b0;

   leapfrog_verlet_pbc_step uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_pos_z     (req_pos_z),
      .req_vel_x     (req_vel_x),
      .req_vel_y     (req_vel_y),
      .req_vel_z     (req_vel_z),
      .req_force_x   (req_force_x),
      .req_force_y   (req_force_y),
      .req_force_z   (req_force_z),
      .req_inv_mass  (req_inv_mass),
      .rsp_valid     (rsp_valid),
      .rsp_new_pos_x (rsp_new_pos_x),
      .rsp_new_pos_y (rsp_new_pos_y),
      .rsp_new_pos_z (rsp_new_pos_z),
      .rsp_new_vel_x (rsp_new_vel_x),
      .rsp_new_vel_y (rsp_new_vel_y),
      .rsp_new_vel_z (rsp_new_vel_z),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // clamp to the signed result width
   function automatic longint clamp_q16(input longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   // inv_mass * force * step sum; the sum is Q0.25, which folds in the half.
   // the full product is Q31.57 and rounds to Q16.16, ties away from zero
   function automatic longint kick_gain(input logic [IM_W-1:0] im, input longint f,
                                        input logic [DTSUM_W-1:0] s);
      logic [63:0]  fm;
      logic [127:0] prod;
      longint       q;
      fm = (f < 0) ? 64'(-f) : 64'(f);
      prod = 128'(im) * 128'(fm) * 128'(s);
      q = longint'((prod + (128'd1 << 40)) >> 41);
      return (f < 0) ? -q : q;
   endfunction

   // velocity (Q16.16) times dt_next (Q0.24), rounded half away from zero
   function automatic longint drift_step(input longint v, input logic [DT_W-1:0] dt);
      logic [63:0] vm;
      longint      q;
      vm = (v < 0) ? 64'(-v) : 64'(v);
      q = longint'((vm * 64'(dt) + 64'd8388608) >> 24);
      return (v < 0) ? -q : q;
   endfunction

   // one leapfrog step of an atom under the current registers
   function automatic motion_type integrate_atom(input atom_type a);
      motion_type            m;
      logic [DTSUM_W-1:0]    s;
      longint                p, v, f, np, nv, low, size;
      s = {1'b0, step_cfg.dt_prev} + {1'b0, step_cfg.dt_next};
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         p = $signed(a.pos[ax]);
         v = $signed(a.vel[ax]);
         f = $signed(a.frc[ax]);
         np = p;
         nv = v;
         // fixed atoms pass through untouched
         if (a.inv_mass != '0) begin
            low = $signed(step_cfg.box_low[ax]);
            size = longint'(step_cfg.box_size[ax]);
            nv = clamp_q16(v + kick_gain(a.inv_mass, f, s));
            np = p + drift_step(nv, step_cfg.dt_next);
            // single wrap, unsaturated position against the box bounds
            if (np < low) begin
               np = np + size;
            end else if (np > low + size) begin
               np = np - size;
            end
            np = clamp_q16(np);
         end
         m.pos[ax] = 32'(np);
         m.vel[ax] = 32'(nv);
      end
      return m;
   endfunction

   // ------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 40) begin
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   // random pause after a handshake, skipped during the no-idle stretch
   function automatic int pick_gap();
      if (no_idle || $urandom_range(0, 99) >= 30) begin
         return 0;
      end
      return $urandom_range(1, MAX_GAP);
   endfunction

   // one register write; valid stays high for a back-to-back write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      int gap;
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      reg_writes++;
      case (idx)
         REG_DT_PREV: step_cfg.dt_prev = data[DT_W-1:0];
         REG_DT_NEXT: step_cfg.dt_next = data[DT_W-1:0];
         REG_BOX_LOW_X, REG_BOX_LOW_Y, REG_BOX_LOW_Z:
            step_cfg.box_low[idx - REG_BOX_LOW_X] = data;
         REG_BOX_SIZE_X, REG_BOX_SIZE_Y, REG_BOX_SIZE_Z:
            step_cfg.box_size[idx - REG_BOX_SIZE_X] = data[SIZE_W-1:0];
         default: ; // unused index, the write is dropped
      endcase
      gap = pick_gap();
      if (gap != 0) begin
         csr_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // all eight registers, with junk in the bits above each field
   task automatic program_cfg(input step_cfg_type c);
      logic [DATA_W-1:0] junk;
      junk = $urandom;
      write_reg(REG_DT_PREV, {junk[DATA_W-1:DT_W], c.dt_prev});
      junk = $urandom;
      write_reg(REG_DT_NEXT, {junk[DATA_W-1:DT_W], c.dt_next});
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         write_reg(CSR_IDX_W'(REG_BOX_LOW_X + ax), c.box_low[ax]);
      end
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         junk = $urandom;
         write_reg(CSR_IDX_W'(REG_BOX_SIZE_X + ax), {junk[DATA_W-1], c.box_size[ax]});
      end
      csr_valid <= 1'b0;
   endtask

   // one atom request; the prediction is taken when the block accepts it
   task automatic send_atom(input atom_type a);
      int gap;
      req_pos_x    <= a.pos[0];
      req_pos_y    <= a.pos[1];
      req_pos_z    <= a.pos[2];
      req_vel_x    <= a.vel[0];
      req_vel_y    <= a.vel[1];
      req_vel_z    <= a.vel[2];
      req_force_x  <= a.frc[0];
      req_force_y  <= a.frc[1];
      req_force_z  <= a.frc[2];
      req_inv_mass <= a.inv_mass;
      start        <= 1'b1;
      do @(posedge clock); while (busy);
      pending_motion_q.push_back(integrate_atom(a));
      atoms_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending, drain the pipe and let it settle before register writes
   task automatic quiesce();
      start <= 1'b0;
      while (pending_motion_q.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   function automatic atom_type make_atom(
      input logic [DATA_W-1:0] px, py, pz, vx, vy, vz, fx, fy, fz,
      input logic [IM_W-1:0] im);
      atom_type a;
      a.pos      = {pz, py, px};
      a.vel      = {vz, vy, vx};
      a.frc      = {fz, fy, fx};
      a.inv_mass = im;
      return a;
   endfunction

   function automatic step_cfg_type uniform_cfg(
      input logic [DT_W-1:0] dtp, dtn, input logic [DATA_W-1:0] low,
      input logic [SIZE_W-1:0] size);
      step_cfg_type c;
      c.dt_prev  = dtp;
      c.dt_next  = dtn;
      c.box_low  = {low, low, low};
      c.box_size = {size, size, size};
      return c;
   endfunction

   // random Q16.16 with a random magnitude, so not everything saturates
   function automatic logic [DATA_W-1:0] random_q16();
      logic [DATA_W-1:0] r;
      r = $urandom;
      if ($urandom_range(0, 3) == 0) begin
         return r;
      end
      return 32'($signed(r) >>> $urandom_range(1, 31));
   endfunction

   function automatic atom_type random_atom();
      atom_type a;
      longint   low, size, off;
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         // about half the positions land around the box to exercise wrapping
         if ($urandom_range(0, 1) == 0) begin
            a.pos[ax] = random_q16();
         end else begin
            low = $signed(step_cfg.box_low[ax]);
            size = longint'(step_cfg.box_size[ax]);
            off = longint'($urandom_range(0, 1000)) * (size * 2) / 1000 - size / 2;
            a.pos[ax] = 32'(low + off);
         end
         a.vel[ax] = random_q16();
         a.frc[ax] = random_q16();
      end
      case ($urandom_range(0, 9))
         0: a.inv_mass = '0;
         1: a.inv_mass = IM_MAX;
         default: a.inv_mass = IM_W'($urandom) >> $urandom_range(0, 30);
      endcase
      return a;
   endfunction

   function automatic step_cfg_type random_cfg();
      step_cfg_type c;
      case ($urandom_range(0, 3))
         0: c.dt_prev = '0;
         1: c.dt_prev = DT_MAX;
         default: c.dt_prev = DT_W'($urandom) >> $urandom_range(0, 23);
      endcase
      case ($urandom_range(0, 3))
         0: c.dt_next = '0;
         1: c.dt_next = DT_MAX;
         default: c.dt_next = DT_W'($urandom) >> $urandom_range(0, 23);
      endcase
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         case ($urandom_range(0, 5))
            0: c.box_low[ax] = Q16_MIN;
            1: c.box_low[ax] = Q16_MAX;
            default: c.box_low[ax] = random_q16();
         endcase
         case ($urandom_range(0, 5))
            0: c.box_size[ax] = '0;
            1: c.box_size[ax] = SIZE_MAX;
            default: c.box_size[ax] = SIZE_W'($urandom) >> $urandom_range(0, 30);
         endcase
      end
      return c;
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // registers still at their reset value of zero
   task automatic test_reset_values();
      send_atom(make_atom(Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX,
                          Q16_MAX, Q16_MAX, Q16_MAX, IM_MAX));
      send_atom(make_atom(Q16_MIN, Q16_MIN, Q16_MIN, Q16_MIN, Q16_MIN, Q16_MIN,
                          Q16_MIN, Q16_MIN, Q16_MIN, 31'd1));
      send_atom(make_atom(-1, 1, -Q16_ONE, Q16_ONE, -1, 0, 5, -5, 0, '0));
      quiesce();
   endtask

   // zero inverse mass: position and velocity come back as they went in
   task automatic test_fixed_atoms();
      program_cfg(uniform_cfg(DT_MAX, DT_MAX, 0, 31'(Q16_ONE)));
      send_atom(make_atom(Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX,
                          Q16_MAX, Q16_MAX, Q16_MAX, '0));
      send_atom(make_atom(Q16_MIN, Q16_MIN, Q16_MIN, Q16_MIN, Q16_MIN, Q16_MIN,
                          Q16_MIN, Q16_MIN, Q16_MIN, '0));
      send_atom(make_atom(Q16_MAX, Q16_MIN, -1, Q16_MIN, Q16_MAX, 1,
                          Q16_MIN, Q16_MAX, -1, '0));
      quiesce();
   endtask

   // largest steps and masses drive velocity and position into saturation
   task automatic test_saturation();
      program_cfg(uniform_cfg(DT_MAX, DT_MAX, Q16_MIN, SIZE_MAX));
      send_atom(make_atom(Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX,
                          Q16_MAX, Q16_MAX, Q16_MAX, IM_MAX));
      send_atom(make_atom(Q16_MIN, Q16_MIN, Q16_MIN, Q16_MIN, Q16_MIN, Q16_MIN,
                          Q16_MIN, Q16_MIN, Q16_MIN, IM_MAX));
      send_atom(make_atom(Q16_MAX, Q16_MIN, 0, Q16_MAX, Q16_MIN, Q16_MAX,
                          Q16_MIN, Q16_MAX, Q16_MIN, 31'd1));
      send_atom(make_atom(0, -1, Q16_MAX, -Q16_ONE, Q16_ONE, Q16_MAX,
                          Q16_ONE, -Q16_ONE, Q16_MAX, 31'(Q16_ONE)));
      quiesce();
   endtask

   // exact halves in both roundings must go away from zero
   task automatic test_rounding_ties();
      program_cfg(uniform_cfg(DT_HALF, DT_HALF, 32'shC000_0000, SIZE_MAX));
      // gain of exactly one half lsb before rounding
      send_atom(make_atom(0, 0, 0, 0, 0, 0, 2, -2, 2, 31'h8000));
      send_atom(make_atom(0, 0, 0, 0, 0, 0, -2, 2, -2, 31'h8000));
      // position step of exactly one half lsb
      send_atom(make_atom(0, 0, 0, 1, -1, 3, 0, 0, 0, 31'd1));
      send_atom(make_atom(0, 0, 0, -3, 3, -1, 0, 0, 0, 31'd1));
      quiesce();
   endtask

   // wrapping only, with no motion: below, above, on the bounds,
   // far outside (one wrap only) and a zero-size axis
   task automatic test_box_wrap();
      step_cfg_type c;
      logic signed [DATA_W-1:0] lo, hi, sz;
      lo = -32'sd655360;
      sz = 32'sd1310720;
      hi = lo + sz;
      c = uniform_cfg(0, 0, lo, 31'(sz));
      c.box_size[2] = '0;
      program_cfg(c);
      send_atom(make_atom(lo - 1, hi + 1, lo - 1, 0, 0, 0, 0, 0, 0, 31'd1));
      send_atom(make_atom(lo, hi, hi + 1, 0, 0, 0, 0, 0, 0, 31'd1));
      send_atom(make_atom(lo - 3 * sz, hi + 3 * sz, 0, 0, 0, 0, 0, 0, 0, 31'd1));
      quiesce();
   endtask

   // writes to indexes past the map must leave the registers alone
   task automatic test_unused_index();
      write_reg(FIRST_UNUSED_INDEX, $urandom);
      write_reg(LAST_INDEX, $urandom);
      write_reg(CSR_IDX_W'($urandom_range(FIRST_UNUSED_INDEX + 1, LAST_INDEX - 1)),
                $urandom);
      csr_valid <= 1'b0;
      send_atom(make_atom(Q16_ONE, -Q16_ONE, 0, Q16_ONE, Q16_ONE, -Q16_ONE,
                          Q16_ONE, 0, -Q16_ONE, 31'(Q16_ONE)));
      send_atom(random_atom());
      quiesce();
   endtask

   // random atoms under several random register settings; one phase
   // streams an atom every cycle
   task automatic test_random_atoms();
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         program_cfg(random_cfg());
         no_idle = (ph == 3);
         repeat (ATOMS_PER_PHASE) send_atom(random_atom());
         no_idle = 1'b0;
         quiesce();
      end
   endtask

   // ------------------------------------------------------------------
   // result checker: every rsp_valid cycle is compared with the oldest
   // prediction, axis by axis
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      motion_type want;
      motion_type got;
      string      axis_name;
      if (!reset && rsp_valid) begin
         got.pos = {rsp_new_pos_z, rsp_new_pos_y, rsp_new_pos_x};
         got.vel = {rsp_new_vel_z, rsp_new_vel_y, rsp_new_vel_x};
         if (pending_motion_q.size() == 0) begin
            report_mismatch($sformatf("result with no request outstanding pos %h vel %h",
                                      got.pos, got.vel));
         end else begin
            want = pending_motion_q.pop_front();
            motions_checked++;
            for (int ax = 0; ax < NUM_AXES; ax++) begin
               axis_name = (ax == 0) ? "x" : (ax == 1) ? "y" : "z";
               if (got.pos[ax] !== want.pos[ax]) begin
                  report_mismatch($sformatf("new_pos_%s got %h want %h", axis_name,
                                            got.pos[ax], want.pos[ax]));
               end
               if (got.vel[ax] !== want.vel[ax]) begin
                  report_mismatch($sformatf("new_vel_%s got %h want %h", axis_name,
                                            got.vel[ax], want.vel[ax]));
               end
            end
         end
      end
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_motion_q.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      // synchronous reset, released once
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_fixed_atoms();
      test_saturation();
      test_rounding_ties();
      test_box_wrap();
      test_unused_index();
      test_random_atoms();

      quiesce();
      if (pending_motion_q.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", pending_motion_q.size()));
      end

      $display("run covered %0d atoms and %0d register writes over %0d cycles",
               atoms_sent, reg_writes, cycle_count);
      $display("%0d results compared, %0d mismatches", motions_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
